// ===== src/lc2u_pkg.sv =====
// ----------------------------------------------------------------------------
// lc2u_pkg: shared types and functions for the label charset converter
// Charset codes, the EBU Latin upper-half table and the UTF-8 encoder.
// ----------------------------------------------------------------------------
package lc2u_pkg;

	localparam int ByteW   = 8;
	localparam int CsW     = 4;
	localparam int CpW     = 16;
	localparam int MaxOut  = 3;
	localparam int CntW    = 2;

	localparam logic [CsW-1:0] CS_LATIN1 = 4'd6;
	localparam logic [CsW-1:0] CS_UTF8   = 4'd15;
	localparam logic [CsW-1:0] CS_RESET  = 4'd0;

	// up to three encoded bytes, bytes[0] goes out first
	typedef struct packed {
		logic [CntW-1:0]                cnt;
		logic [MaxOut-1:0][ByteW-1:0]   bytes;
	} enc_result_t;

	// status of the output stage, seen by the top level
	typedef struct packed {
		logic            valid;
		logic [CntW-1:0] rem;
		logic            can_load;
	} out_stat_t;

	// EBU Latin code points for bytes 0x80 to 0xFF
	localparam logic [CpW-1:0] UPPER_MAP [128] = '{
		16'h00E1, 16'h00E0, 16'h00E9, 16'h00E8, 16'h00ED, 16'h00EC, 16'h00F3, 16'h00F2,
		16'h00FA, 16'h00F9, 16'h00D1, 16'h00C7, 16'h015E, 16'h00DF, 16'h00A1, 16'h0132,
		16'h00E2, 16'h00E4, 16'h00EA, 16'h00EB, 16'h00EE, 16'h00EF, 16'h00F4, 16'h00F6,
		16'h00FB, 16'h00FC, 16'h00F1, 16'h00E7, 16'h015F, 16'h011F, 16'h0131, 16'h0133,
		16'h00AA, 16'h03B1, 16'h00A9, 16'h2030, 16'h011E, 16'h011B, 16'h0148, 16'h0151,
		16'h03C0, 16'h20AC, 16'h00A3, 16'h0024, 16'h2190, 16'h2191, 16'h2192, 16'h2193,
		16'h00BA, 16'h00B9, 16'h00B2, 16'h00B3, 16'h00B1, 16'h0130, 16'h0144, 16'h0171,
		16'h00B5, 16'h00BF, 16'h00F7, 16'h00B0, 16'h00BC, 16'h00BD, 16'h00BE, 16'h00A7,
		16'h00C1, 16'h00C0, 16'h00C9, 16'h00C8, 16'h00CD, 16'h00CC, 16'h00D3, 16'h00D2,
		16'h00DA, 16'h00D9, 16'h0158, 16'h010C, 16'h0160, 16'h017D, 16'h00D0, 16'h013F,
		16'h00C2, 16'h00C4, 16'h00CA, 16'h00CB, 16'h00CE, 16'h00CF, 16'h00D4, 16'h00D6,
		16'h00DB, 16'h00DC, 16'h0159, 16'h010D, 16'h0161, 16'h017E, 16'h0111, 16'h0140,
		16'h00C3, 16'h00C5, 16'h00C6, 16'h0152, 16'h0177, 16'h00DD, 16'h00D5, 16'h00D8,
		16'h00DE, 16'h014A, 16'h0154, 16'h0106, 16'h015A, 16'h0179, 16'h0166, 16'h00F0,
		16'h00E3, 16'h00E5, 16'h00E6, 16'h0153, 16'h0175, 16'h00FD, 16'h00F5, 16'h00F8,
		16'h00FE, 16'h014B, 16'h0155, 16'h0107, 16'h015B, 16'h017A, 16'h0167, 16'h00FF
	};

	function automatic logic [CpW-1:0] ebu_code_point(input logic [ByteW-1:0] b);
		logic [CpW-1:0] cp;
		if (b[7]) begin
			cp = UPPER_MAP[b[6:0]];
		end else if (b == 8'h24) begin
			cp = 16'h00A4;
		end else begin
			cp = {8'h00, b};
		end
		return cp;
	endfunction

	function automatic enc_result_t utf8_encode(input logic [CpW-1:0] cp);
		enc_result_t r;
		r.bytes = '0;
		if (cp < 16'h0080) begin
			r.cnt      = 2'd1;
			r.bytes[0] = cp[7:0];
		end else if (cp < 16'h0800) begin
			r.cnt      = 2'd2;
			r.bytes[0] = {3'b110, cp[10:6]};
			r.bytes[1] = {2'b10, cp[5:0]};
		end else begin
			r.cnt      = 2'd3;
			r.bytes[0] = {4'b1110, cp[15:12]};
			r.bytes[1] = {2'b10, cp[11:6]};
			r.bytes[2] = {2'b10, cp[5:0]};
		end
		return r;
	endfunction

endpackage

// ===== src/lc2u_encode.sv =====
// ----------------------------------------------------------------------------
// lc2u_encode: byte to UTF-8 conversion
// Combinational: picks the mode from the charset code and encodes one byte.
// ----------------------------------------------------------------------------
module lc2u_encode (
	input  logic [lc2u_pkg::ByteW-1:0] label_byte,
	input  logic [lc2u_pkg::CsW-1:0]   char_set,
	input  logic                       stopped,
	output lc2u_pkg::enc_result_t      result
);
	import lc2u_pkg::*;

	enc_result_t conv;

	always_comb begin
		case (char_set)
			CS_UTF8: begin
				conv          = '0;
				conv.cnt      = 2'd1;
				conv.bytes[0] = label_byte;
			end
			CS_LATIN1: conv = utf8_encode({8'h00, label_byte});
			default:   conv = utf8_encode(ebu_code_point(label_byte));
		endcase
	end

	// stopped label or NUL: nothing emitted
	always_comb begin
		result = conv;
		if (stopped || (label_byte == '0)) begin
			result.cnt = '0;
		end
	end

endmodule

// ===== src/lc2u_out.sv =====
// ----------------------------------------------------------------------------
// lc2u_out: result register and byte serializer
// Holds up to three encoded bytes and hands them out one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module lc2u_out (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load_valid,
	input  lc2u_pkg::enc_result_t         load_data,
	input  logic                          out_ready,
	output logic [lc2u_pkg::ByteW-1:0]    utf8_byte,
	output logic                          run_last,
	output lc2u_pkg::out_stat_t           stat
);
	import lc2u_pkg::*;

	logic [MaxOut-1:0][ByteW-1:0] bytes_s2;
	logic [CntW-1:0]              rem_s2;
	logic                         valid_s2;
	logic                         emit;
	logic                         can_load;

	assign emit     = valid_s2 && out_ready;
	assign can_load = !valid_s2 || (out_ready && (rem_s2 == 2'd1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			rem_s2   <= '0;
		end else if (load_valid && can_load) begin
			valid_s2 <= (load_data.cnt != '0);
			rem_s2   <= load_data.cnt;
		end else if (emit) begin
			valid_s2 <= (rem_s2 != 2'd1);
			rem_s2   <= rem_s2 - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_valid && can_load) begin
			bytes_s2 <= load_data.bytes;
		end else if (emit) begin
			bytes_s2 <= {8'h00, bytes_s2[2:1]};
		end
	end

	assign utf8_byte      = bytes_s2[0];
	assign run_last       = (rem_s2 == 2'd1);
	assign stat.valid     = valid_s2;
	assign stat.rem       = rem_s2;
	assign stat.can_load  = can_load;

endmodule

// ===== src/label_charset_to_utf8_top.sv =====
// ----------------------------------------------------------------------------
// label_charset_to_utf8_top: label byte to UTF-8 converter
// Input register, byte encoder and a serializing result register.
// ----------------------------------------------------------------------------
// Usage:
//  - cfg channel (cfg_valid/cfg_ready/cfg_data) writes the 4-bit charset code:
//    6 Latin-1, 15 UTF-8 passthrough, any other code EBU Latin. cfg_ready is
//    always high; write only while no request is in flight.
//  - in channel carries one label byte per request, label_last on the final
//    byte of a label. A NUL byte silences the rest of the label; the request
//    with label_last re-arms output for the next label.
//  - out channel gives one UTF-8 byte per request; run_last marks the last
//    byte produced by one input byte.
// Path: an accepted byte is held in the input register, then loaded into the
//   result register, whose output carries the first UTF-8 byte.
// Throughput: one output byte per cycle while out_ready is high, so an input
//   byte occupies the result register for 1 to 3 output bytes, the length of
//   its UTF-8 encoding. A byte that yields nothing (NUL, stopped label) is not held.
// Stall: when out_ready is low the result register holds, the input register
//   fills behind it and in_ready drops; nothing is dropped.
// Reset: arst_n clears both stages, the stop flag and the charset (to 0).
// ----------------------------------------------------------------------------
module label_charset_to_utf8_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lc2u_pkg::CsW-1:0]      cfg_data,
	// label bytes in
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [lc2u_pkg::ByteW-1:0]    label_byte,
	input  logic                          label_last,
	// UTF-8 bytes out
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lc2u_pkg::ByteW-1:0]    utf8_byte,
	output logic                          run_last
);
	import lc2u_pkg::*;

	logic [CsW-1:0]   char_set_q;
	logic             stopped_q;
	logic             valid_s1;
	logic [ByteW-1:0] byte_s1;
	logic             last_s1;
	logic             adv_s1;
	enc_result_t      enc;
	out_stat_t        ostat;

	// config register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_set_q <= CS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			char_set_q <= cfg_data;
		end
	end

	// input register; frees up whenever its item moves into the result stage
	assign adv_s1   = valid_s1 && ostat.can_load;
	assign in_ready = !valid_s1 || ostat.can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= label_byte;
			last_s1 <= label_last;
		end
	end

	// stop flag advances in item order, as each item leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stopped_q <= 1'b0;
		end else if (adv_s1) begin
			stopped_q <= !last_s1 && (stopped_q || (byte_s1 == '0));
		end
	end

	lc2u_encode u_encode (
		.label_byte (byte_s1),
		.char_set   (char_set_q),
		.stopped    (stopped_q),
		.result     (enc)
	);

	lc2u_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1),
		.load_data  (enc),
		.out_ready  (out_ready),
		.utf8_byte  (utf8_byte),
		.run_last   (run_last),
		.stat       (ostat)
	);

	assign out_valid = ostat.valid;

`ifndef SYNTHESIS
	// a shown byte always has a count behind it
	a_valid_has_rem: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (ostat.rem != 2'd0))
		else $error("output valid with empty result register");

	// a stopped label yields nothing
	a_stopped_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && stopped_q) |-> (enc.cnt == 2'd0))
		else $error("bytes produced while stopped");

	// the first byte of a three-byte run is a three-byte lead
	a_lead3: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ostat.rem == 2'd3) |-> (utf8_byte[7:4] == 4'hE))
		else $error("bad lead byte for three-byte sequence");

	// a NUL that does not end the label stops the label
	a_nul_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && byte_s1 == 8'h00 && !last_s1) |=> stopped_q)
		else $error("NUL byte did not stop the label");
`endif

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for label_charset_to_utf8_top
// Directed and random label streams are sent through the converter under
// several charset codes. Each byte that goes in is predicted here into its
// UTF-8 bytes, and every byte that comes out is checked against them in order.
// ----------------------------------------------------------------------------
module tb;

	// run limits
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 6;    // two-stage pipe plus margin
	localparam int RANDOM_ITEMS  = 290;
	localparam int RANDOM_PHASES = 10;

	// charset codes the package does not name; all of them select EBU Latin
	localparam logic [lc2u_pkg::CsW-1:0] CS_EBU_ALT1   = 4'd1;
	localparam logic [lc2u_pkg::CsW-1:0] CS_EBU_ALT2   = 4'd2;
	localparam logic [lc2u_pkg::CsW-1:0] CS_UNKNOWN    = 4'd9;
	localparam logic [lc2u_pkg::CsW-1:0] CS_UNKNOWN_HI = 4'd14;

	localparam logic [7:0]  NUL_BYTE    = 8'h00;
	localparam logic [7:0]  DOLLAR_BYTE = 8'h24;
	localparam logic [15:0] CURRENCY_CP = 16'h00A4;

	// EBU Latin code points for bytes 0x80..0xFF
	localparam logic [15:0] EBU_UPPER [128] = '{
		16'h00E1, 16'h00E0, 16'h00E9, 16'h00E8, 16'h00ED, 16'h00EC, 16'h00F3, 16'h00F2,
		16'h00FA, 16'h00F9, 16'h00D1, 16'h00C7, 16'h015E, 16'h00DF, 16'h00A1, 16'h0132,
		16'h00E2, 16'h00E4, 16'h00EA, 16'h00EB, 16'h00EE, 16'h00EF, 16'h00F4, 16'h00F6,
		16'h00FB, 16'h00FC, 16'h00F1, 16'h00E7, 16'h015F, 16'h011F, 16'h0131, 16'h0133,
		16'h00AA, 16'h03B1, 16'h00A9, 16'h2030, 16'h011E, 16'h011B, 16'h0148, 16'h0151,
		16'h03C0, 16'h20AC, 16'h00A3, 16'h0024, 16'h2190, 16'h2191, 16'h2192, 16'h2193,
		16'h00BA, 16'h00B9, 16'h00B2, 16'h00B3, 16'h00B1, 16'h0130, 16'h0144, 16'h0171,
		16'h00B5, 16'h00BF, 16'h00F7, 16'h00B0, 16'h00BC, 16'h00BD, 16'h00BE, 16'h00A7,
		16'h00C1, 16'h00C0, 16'h00C9, 16'h00C8, 16'h00CD, 16'h00CC, 16'h00D3, 16'h00D2,
		16'h00DA, 16'h00D9, 16'h0158, 16'h010C, 16'h0160, 16'h017D, 16'h00D0, 16'h013F,
		16'h00C2, 16'h00C4, 16'h00CA, 16'h00CB, 16'h00CE, 16'h00CF, 16'h00D4, 16'h00D6,
		16'h00DB, 16'h00DC, 16'h0159, 16'h010D, 16'h0161, 16'h017E, 16'h0111, 16'h0140,
		16'h00C3, 16'h00C5, 16'h00C6, 16'h0152, 16'h0177, 16'h00DD, 16'h00D5, 16'h00D8,
		16'h00DE, 16'h014A, 16'h0154, 16'h0106, 16'h015A, 16'h0179, 16'h0166, 16'h00F0,
		16'h00E3, 16'h00E5, 16'h00E6, 16'h0153, 16'h0175, 16'h00FD, 16'h00F5, 16'h00F8,
		16'h00FE, 16'h014B, 16'h0155, 16'h0107, 16'h015B, 16'h017A, 16'h0167, 16'h00FF
	};

	// one expected output byte
	typedef struct packed {
		logic [7:0] utf8_byte;
		logic       run_last;
	} utf8_out_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [lc2u_pkg::CsW-1:0]       cfg_data;
	logic                           in_valid;
	logic                           in_ready;
	logic [lc2u_pkg::ByteW-1:0]     label_byte;
	logic                           label_last;
	logic                           out_valid;
	logic                           out_ready;
	logic [lc2u_pkg::ByteW-1:0]     utf8_byte;
	logic                           run_last;

	// predictor state, mirrors the block
	logic [lc2u_pkg::CsW-1:0]       active_charset;
	bit                             label_stopped;
	utf8_out_t                      utf8_pending [$];

	// bookkeeping
	bit                             steady;      // no idling on either side
	int                             fails;
	int                             items_sent;
	int                             bytes_checked;
	int                             cfg_writes;
	int                             cycles;

	label_charset_to_utf8_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.label_byte (label_byte),
		.label_last (label_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.utf8_byte  (utf8_byte),
		.run_last   (run_last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost byte ends here.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Idle length: mostly none or short, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	// ---------------- predictor ----------------

	function automatic void queue_out(logic [7:0] b, logic is_last);
		utf8_out_t o;
		o.utf8_byte = b;
		o.run_last  = is_last;
		utf8_pending = {utf8_pending, o};
	endfunction

	// UTF-8 encode a 16-bit code point into 1..3 expected bytes
	function automatic void queue_code_point(logic [15:0] cp);
		if (cp < 16'h0080) begin
			queue_out(cp[7:0], 1'b1);
		end else if (cp < 16'h0800) begin
			queue_out({3'b110, cp[10:6]}, 1'b0);
			queue_out({2'b10, cp[5:0]}, 1'b1);
		end else begin
			queue_out({4'b1110, cp[15:12]}, 1'b0);
			queue_out({2'b10, cp[11:6]}, 1'b0);
			queue_out({2'b10, cp[5:0]}, 1'b1);
		end
	endfunction

	// Works out what one accepted label byte produces and updates stop state.
	function automatic void convert_label_byte(logic [7:0] b, logic is_last);
		if (!label_stopped) begin
			if (b == NUL_BYTE) begin
				label_stopped = 1'b1;
			end else if (active_charset == lc2u_pkg::CS_UTF8) begin
				queue_out(b, 1'b1);
			end else if (active_charset == lc2u_pkg::CS_LATIN1) begin
				queue_code_point({8'h00, b});
			end else if (b[7]) begin
				queue_code_point(EBU_UPPER[b[6:0]]);
			end else if (b == DOLLAR_BYTE) begin
				// EBU Latin puts the currency sign where ASCII has the dollar
				queue_code_point(CURRENCY_CP);
			end else begin
				queue_code_point({8'h00, b});
			end
		end
		// label end re-arms output, even when this byte was NUL
		if (is_last)
			label_stopped = 1'b0;
	endfunction

	// ---------------- drivers ----------------

	// Send one label byte; returns right after the accepting edge.
	// Valid stays high across back-to-back requests.
	task automatic push_label_byte(logic [7:0] b, logic is_last);
		int g;
		g = steady ? 0 : gap_len();
		@(negedge clk);
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_valid   <= 1'b1;
		label_byte <= b;
		label_last <= is_last;
		do @(posedge clk); while (!in_ready);
		convert_label_byte(b, is_last);
		items_sent++;
	endtask

	// Stop sending and let the pipe empty: all expected bytes out, then
	// a few more edges since NUL or stopped bytes leave nothing to wait on.
	task automatic drain_outputs();
		@(negedge clk);
		in_valid <= 1'b0;
		while (utf8_pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Charset write, only called with the pipe drained.
	task automatic write_charset(logic [lc2u_pkg::CsW-1:0] cs);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= cs;
		do @(posedge clk); while (!cfg_ready);
		active_charset = cs;
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Receiver: ready drops for random stretches, or stays high when steady.
	initial begin
		int n;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			n = steady ? 0 : gap_len();
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
	end

	// ---------------- checker ----------------

	// Every output request is matched against the oldest expected byte.
	always @(posedge clk) begin
		utf8_out_t want;
		if (arst_n && out_valid && out_ready) begin
			bytes_checked++;
			if (utf8_pending.size() == 0) begin
				$error("unexpected output: utf8_byte %h run_last %b", utf8_byte, run_last);
				fails++;
			end else begin
				want = utf8_pending.pop_front();
				if (utf8_byte !== want.utf8_byte) begin
					$error("utf8_byte: expected %h, got %h", want.utf8_byte, utf8_byte);
					fails++;
				end
				if (run_last !== want.run_last) begin
					$error("run_last: expected %b, got %b", want.run_last, run_last);
					fails++;
				end
			end
		end
	end

	// ---------------- tests ----------------

	// Charset left at its reset value: EBU Latin over the byte range,
	// one-, two- and three-byte encodings.
	task automatic test_reset_charset();
		push_label_byte(8'h41, 1'b0);
		push_label_byte(DOLLAR_BYTE, 1'b0);   // currency sign, 2 bytes
		push_label_byte(8'hA3, 1'b0);         // per-mille sign, 3 bytes
		push_label_byte(8'h80, 1'b0);
		push_label_byte(8'hFF, 1'b0);
		push_label_byte(8'h7F, 1'b0);
		push_label_byte(8'h01, 1'b1);
		drain_outputs();
	endtask

	// NUL silences the label until the byte marked last, which itself
	// still produces nothing; a NUL that is also last stops nothing after.
	task automatic test_nul_stop();
		push_label_byte(8'h41, 1'b0);
		push_label_byte(NUL_BYTE, 1'b0);
		push_label_byte(8'hA9, 1'b0);
		push_label_byte(NUL_BYTE, 1'b0);
		push_label_byte(8'h43, 1'b1);
		push_label_byte(8'h44, 1'b0);
		push_label_byte(NUL_BYTE, 1'b1);
		push_label_byte(8'h45, 1'b1);
		drain_outputs();
	endtask

	task automatic test_latin1();
		write_charset(lc2u_pkg::CS_LATIN1);
		push_label_byte(8'h7F, 1'b0);
		push_label_byte(8'h80, 1'b0);
		push_label_byte(8'hFF, 1'b0);
		push_label_byte(DOLLAR_BYTE, 1'b1);
		drain_outputs();
	endtask

	// Passthrough emits high bytes as they are, even if not valid UTF-8.
	task automatic test_passthrough();
		write_charset(lc2u_pkg::CS_UTF8);
		push_label_byte(8'hFF, 1'b0);
		push_label_byte(8'h80, 1'b0);
		push_label_byte(DOLLAR_BYTE, 1'b0);
		push_label_byte(NUL_BYTE, 1'b0);
		push_label_byte(8'h41, 1'b1);
		drain_outputs();
	endtask

	// Codes that name no charset fall back to EBU Latin.
	task automatic test_unknown_charset();
		write_charset(CS_UNKNOWN);
		push_label_byte(8'hA3, 1'b1);
		drain_outputs();
	endtask

	// Random labels in phases, each under a charset written at its start. Most traffic is
	// whole labels of nonzero bytes with the odd NUL; some is loose noise.
	task automatic test_random_labels();
		int                       phase;
		int                       sent;
		int                       len;
		logic [lc2u_pkg::CsW-1:0] cs;
		logic [7:0]               b;
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase % 8)
				0: begin
					cs = lc2u_pkg::CS_RESET;
				end
				1: begin
					cs = CS_EBU_ALT1;
				end
				2: begin
					cs = CS_EBU_ALT2;
				end
				3: begin
					cs = lc2u_pkg::CS_LATIN1;
				end
				4: begin
					cs = lc2u_pkg::CS_UTF8;
				end
				5: begin
					cs = CS_UNKNOWN_HI;
				end
				default: begin
					cs = lc2u_pkg::CsW'($urandom_range(0, 15));
				end
			endcase
			write_charset(cs);
			steady = (phase % 4 == 2);
			sent = 0;
			while (sent < RANDOM_ITEMS / RANDOM_PHASES) begin
				if ($urandom_range(0, 9) == 0) begin
					push_label_byte(8'($urandom), 1'($urandom));
					sent++;
				end else begin
					len = $urandom_range(1, 12);
					// keep the phase on its share of items
					if (len > RANDOM_ITEMS / RANDOM_PHASES - sent)
						len = RANDOM_ITEMS / RANDOM_PHASES - sent;
					for (int k = 0; k < len; k++) begin
						b = ($urandom_range(0, 19) == 0) ? NUL_BYTE
							: 8'($urandom_range(1, 255));
						push_label_byte(b, k == len - 1);
						sent++;
					end
				end
			end
			drain_outputs();
		end
		steady = 1'b0;
	endtask

	// ---------------- sequence ----------------

	initial begin
		arst_n         = 1'b0;
		cfg_valid      = 1'b0;
		cfg_data       = '0;
		in_valid       = 1'b0;
		label_byte     = '0;
		label_last     = 1'b0;
		active_charset = lc2u_pkg::CS_RESET;
		label_stopped  = 1'b0;
		steady         = 1'b0;
		items_sent     = 0;
		cfg_writes     = 0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_charset();
		test_nul_stop();
		test_latin1();
		test_passthrough();
		test_unknown_charset();
		test_random_labels();

		$display("Sent %0d label bytes over %0d charset writes; checked %0d UTF-8 bytes.",
			items_sent, cfg_writes, bytes_checked);
		$display("Covered EBU Latin, Latin-1, passthrough, unknown codes, NUL stop and label end.");
		if (fails == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
